// ===== design/ip2p_pkg.sv =====
package ip2p_pkg;

	// Field widths fixed by the token format.
	localparam int OP_W   = 3;
	localparam int CODE_W = 32;
	localparam int PREC_W = 4;

	// Default number of operator stack cells.
	localparam int DEFAULT_STACK_DEPTH = 32;

	// Token kinds.
	localparam logic [OP_W-1:0] OP_NUMBER = 3'd0;
	localparam logic [OP_W-1:0] OP_OPER   = 3'd1;
	localparam logic [OP_W-1:0] OP_LPAREN = 3'd2;
	localparam logic [OP_W-1:0] OP_RPAREN = 3'd3;
	localparam logic [OP_W-1:0] OP_END    = 3'd4;

	// One operator stack entry.
	typedef struct packed {
		logic [CODE_W-1:0] code;
		logic [PREC_W-1:0] prec;
		logic              right;
		logic              lparen;
	} entry_t;

	// Shift control shared by every cell of the stack.
	typedef struct packed {
		logic push;
		logic pop;
	} shift_ctrl_t;

	// True when an incoming operator must pop the stacked entry.
	function automatic logic must_pop(input logic [PREC_W-1:0] prec, input logic right,
			input entry_t stk);
		logic tighter;
		tighter = right ? (prec < stk.prec) : (prec <= stk.prec);
		return !stk.lparen && tighter;
	endfunction

endpackage

// ===== design/ip2p_cell.sv =====
module ip2p_cell (
	input  logic                 clk,
	input  ip2p_pkg::shift_ctrl_t ctrl,
	input  ip2p_pkg::entry_t     from_above,
	input  ip2p_pkg::entry_t     from_below,
	output ip2p_pkg::entry_t     entry
);
	import ip2p_pkg::*;

	entry_t entry_q;

	// A push takes the entry of the cell above, a pop the entry of the cell below.
	always_ff @(posedge clk) begin
		if (ctrl.push) begin
			entry_q <= from_above;
		end else if (ctrl.pop) begin
			entry_q <= from_below;
		end
	end

	assign entry = entry_q;

endmodule

// ===== design/ip2p_stack.sv =====
module ip2p_stack #(
	parameter int STACK_DEPTH = ip2p_pkg::DEFAULT_STACK_DEPTH
) (
	input  logic                  clk,
	input  ip2p_pkg::shift_ctrl_t ctrl,
	input  ip2p_pkg::entry_t      push_entry,
	output ip2p_pkg::entry_t      top0,
	output ip2p_pkg::entry_t      top1
);
	import ip2p_pkg::*;

	entry_t cells [STACK_DEPTH];

	// Row of cells; cell 0 is the top of the stack.
	for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
		entry_t above;
		entry_t below;

		if (i == 0) begin : g_first
			assign above = push_entry;
		end else begin : g_mid_above
			assign above = cells[i-1];
		end

		if (i == STACK_DEPTH - 1) begin : g_last
			assign below = '0;
		end else begin : g_mid_below
			assign below = cells[i+1];
		end

		ip2p_cell u_cell (
			.clk        (clk),
			.ctrl       (ctrl),
			.from_above (above),
			.from_below (below),
			.entry      (cells[i])
		);
	end

	assign top0 = cells[0];
	assign top1 = cells[1];

endmodule

// ===== design/infix_to_postfix_converter.sv =====
// Shunting-yard converter from classified infix tokens to a postfix token stream. The
// operator stack is a row of shifting cells whose top sits in the first cell, so one stack
// entry is pushed or popped per cycle, a pop that emits waiting on a full output register.
// A number gives one result; an operator pops and emits each stacked operator it must pop,
// a right parenthesis those down to its left parenthesis; the end token empties the stack,
// and its last result is a status item whose bad_expression flag tells the consumer to
// discard the expression's tokens (unmatched parenthesis or stack overflow). Results leave
// through an output register, so the block keeps working while a result waits, stalling
// only when a second result is ready.
module infix_to_postfix_converter #(
	parameter int STACK_DEPTH = ip2p_pkg::DEFAULT_STACK_DEPTH
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [ip2p_pkg::OP_W-1:0]     operation,
	input  logic [ip2p_pkg::CODE_W-1:0]   token_code,
	input  logic [ip2p_pkg::PREC_W-1:0]   precedence,
	input  logic                          right_assoc,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [ip2p_pkg::CODE_W-1:0]   out_code,
	output logic                          is_operator,
	output logic                          expression_done,
	output logic                          bad_expression,
	output logic                          last
);
	import ip2p_pkg::*;

	localparam int CNT_W = $clog2(STACK_DEPTH + 1);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_NUM  = 3'd1;
	localparam logic [2:0] S_OPER = 3'd2;
	localparam logic [2:0] S_LPAR = 3'd3;
	localparam logic [2:0] S_RPAR = 3'd4;
	localparam logic [2:0] S_END  = 3'd5;
	localparam logic [2:0] S_STAT = 3'd6;

	logic [2:0]        state_q, state_d;
	logic [CNT_W-1:0]  cnt_q, cnt_d;
	logic              err_q, err_d;
	logic [CODE_W-1:0] code_q;
	logic [PREC_W-1:0] prec_q;
	logic              right_q;

	shift_ctrl_t sctl;
	entry_t      push_entry;
	entry_t      top0, top1;

	logic              emit, emit_ok;
	logic [CODE_W-1:0] emit_code;
	logic              emit_oper, emit_done, emit_bad, emit_last;

	logic              out_valid_q;
	logic [CODE_W-1:0] out_code_q;
	logic              is_operator_q, expression_done_q, bad_expression_q, last_q;

	logic stack_full, stack_empty, stack_two;

	assign in_ready    = (state_q == S_IDLE);
	assign emit_ok     = !out_valid_q || out_ready;
	assign stack_full  = (cnt_q == CNT_W'(STACK_DEPTH));
	assign stack_empty = (cnt_q == '0);
	assign stack_two   = (cnt_q > CNT_W'(1));

	// Operator stack.
	ip2p_stack #(
		.STACK_DEPTH (STACK_DEPTH)
	) u_stack (
		.clk        (clk),
		.ctrl       (sctl),
		.push_entry (push_entry),
		.top0       (top0),
		.top1       (top1)
	);

	// Sequencer: one push or pop and at most one result per cycle, stalling on a full output.
	always_comb begin
		state_d    = state_q;
		cnt_d      = cnt_q;
		err_d      = err_q;
		sctl       = '0;
		push_entry = '{code: code_q, prec: prec_q, right: right_q, lparen: 1'b0};
		emit       = 1'b0;
		emit_code  = top0.code;
		emit_oper  = 1'b1;
		emit_done  = 1'b0;
		emit_bad   = 1'b0;
		emit_last  = 1'b0;

		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					case (operation)
						OP_NUMBER: state_d = S_NUM;
						OP_OPER:   state_d = S_OPER;
						OP_LPAREN: state_d = S_LPAR;
						OP_RPAREN: state_d = S_RPAR;
						OP_END:    state_d = S_END;
						default:   state_d = S_IDLE;
					endcase
				end
			end
			S_NUM: begin
				if (emit_ok) begin
					emit      = 1'b1;
					emit_code = code_q;
					emit_oper = 1'b0;
					emit_last = 1'b1;
					state_d   = S_IDLE;
				end
			end
			S_OPER: begin
				if (!stack_empty && must_pop(prec_q, right_q, top0)) begin
					if (emit_ok) begin
						emit      = 1'b1;
						emit_last = !(stack_two && must_pop(prec_q, right_q, top1));
						sctl.pop  = 1'b1;
						cnt_d     = cnt_q - CNT_W'(1);
					end
				end else begin
					if (stack_full) begin
						err_d = 1'b1;
					end else begin
						sctl.push = 1'b1;
						cnt_d     = cnt_q + CNT_W'(1);
					end
					state_d = S_IDLE;
				end
			end
			S_LPAR: begin
				push_entry = '{code: code_q, prec: '0, right: 1'b0, lparen: 1'b1};
				if (stack_full) begin
					err_d = 1'b1;
				end else begin
					sctl.push = 1'b1;
					cnt_d     = cnt_q + CNT_W'(1);
				end
				state_d = S_IDLE;
			end
			S_RPAR: begin
				if (stack_empty) begin
					// No matching left parenthesis on the stack.
					err_d   = 1'b1;
					state_d = S_IDLE;
				end else if (top0.lparen) begin
					sctl.pop = 1'b1;
					cnt_d    = cnt_q - CNT_W'(1);
					state_d  = S_IDLE;
				end else if (emit_ok) begin
					emit      = 1'b1;
					emit_last = !stack_two || top1.lparen;
					sctl.pop  = 1'b1;
					cnt_d     = cnt_q - CNT_W'(1);
				end
			end
			S_END: begin
				if (stack_empty) begin
					state_d = S_STAT;
				end else if (top0.lparen) begin
					// Left parenthesis left open at the end.
					err_d    = 1'b1;
					sctl.pop = 1'b1;
					cnt_d    = cnt_q - CNT_W'(1);
				end else if (emit_ok) begin
					emit     = 1'b1;
					sctl.pop = 1'b1;
					cnt_d    = cnt_q - CNT_W'(1);
				end
			end
			S_STAT: begin
				if (emit_ok) begin
					emit      = 1'b1;
					emit_code = '0;
					emit_oper = 1'b0;
					emit_done = 1'b1;
					emit_bad  = err_q;
					emit_last = 1'b1;
					err_d     = 1'b0;
					cnt_d     = '0;
					state_d   = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			err_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			err_q   <= err_d;
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Request capture and output payload.
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			code_q  <= token_code;
			prec_q  <= precedence;
			right_q <= right_assoc;
		end
		if (emit) begin
			out_code_q        <= emit_code;
			is_operator_q     <= emit_oper;
			expression_done_q <= emit_done;
			bad_expression_q  <= emit_bad;
			last_q            <= emit_last;
		end
	end

	assign out_valid       = out_valid_q;
	assign out_code        = out_code_q;
	assign is_operator     = is_operator_q;
	assign expression_done = expression_done_q;
	assign bad_expression  = bad_expression_q;
	assign last            = last_q;

	// Checks.
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(STACK_DEPTH))
		else $error("stack count exceeds depth");

	a_shift_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(sctl.push && sctl.pop))
		else $error("push and pop in the same cycle");

	a_last_final: assert property (@(posedge clk) disable iff (!arst_n)
		emit && emit_last |=> !emit)
		else $error("a result follows the last result of a request");

	a_stat_clear: assert property (@(posedge clk) disable iff (!arst_n)
		emit && emit_done |=> cnt_q == '0 && !err_q)
		else $error("state not cleared after status item");

endmodule
